// ===== design/bdsa_pkg.sv =====
// shared types and constants for the button debounce step adjust block
`default_nettype none

package bdsa_pkg;

    localparam int TICK_WIDTH_DEFAULT = 32;

    localparam int COUNT_W    = 8;
    localparam int STEP_W     = 10;
    localparam int DURATION_W = 32;
    localparam int STATE_W    = 2;
    localparam int DIR_W      = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_LOW_LIMIT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_HIGH_LIMIT = 2'd2;

    localparam logic [COUNT_W-1:0] DEBOUNCE_COUNT_RESET  = 8'd20;
    localparam logic [STEP_W-1:0]  STEP_LOW_LIMIT_RESET  = 10'd113;
    localparam logic [STEP_W-1:0]  STEP_HIGH_LIMIT_RESET = 10'd1019;

    // direction codes
    localparam logic [DIR_W-1:0] DIR_DEC = 2'd0;
    localparam logic [DIR_W-1:0] DIR_INC = 2'd1;

    typedef struct packed {
        logic [STATE_W-1:0]    debounced_state;
        logic                  press_event;
        logic                  release_event;
        logic [DURATION_W-1:0] press_duration;
        logic [STEP_W-1:0]     step_value;
    } result_t;

endpackage

`default_nettype wire

// ===== design/bdsa_core.sv =====
// debounce state machine, press timing and saturating step value
`default_nettype none

module bdsa_core #(
    parameter int TICK_WIDTH = bdsa_pkg::TICK_WIDTH_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           step_en,
    input  wire logic                           pin_level,
    input  wire logic [bdsa_pkg::DIR_W-1:0]     direction,
    input  wire logic [TICK_WIDTH-1:0]          now_ticks,
    input  wire logic [bdsa_pkg::COUNT_W-1:0]   debounce_count,
    input  wire logic [bdsa_pkg::STEP_W-1:0]    step_low_limit,
    input  wire logic [bdsa_pkg::STEP_W-1:0]    step_high_limit,
    output bdsa_pkg::result_t                   res
);

    localparam int DUR_W = (TICK_WIDTH < bdsa_pkg::DURATION_W) ? TICK_WIDTH
                                                              : bdsa_pkg::DURATION_W;

    typedef enum logic [bdsa_pkg::STATE_W-1:0] {
        S_UP      = 2'd0,
        S_DOWN    = 2'd1,
        S_FALLING = 2'd2,
        S_RISING  = 2'd3
    } state_t;

    state_t                              state_reg, state_next;
    logic [bdsa_pkg::COUNT_W-1:0]        fall_count_reg, fall_count_next;
    logic [bdsa_pkg::COUNT_W-1:0]        rise_count_reg, rise_count_next;
    logic [TICK_WIDTH-1:0]               press_time_reg, press_time_next;
    logic [bdsa_pkg::DURATION_W-1:0]     duration_reg, duration_next;
    logic [bdsa_pkg::STEP_W-1:0]         step_reg, step_next;
    logic                                press_ev;
    logic                                release_ev;
    logic [TICK_WIDTH-1:0]               elapsed;

    assign elapsed = now_ticks - press_time_reg;

    always_comb
    begin
        logic [bdsa_pkg::COUNT_W-1:0] fall_base;
        logic [bdsa_pkg::COUNT_W-1:0] rise_base;
        state_next      = state_reg;
        fall_count_next = fall_count_reg;
        rise_count_next = rise_count_reg;
        press_time_next = press_time_reg;
        duration_next   = duration_reg;
        step_next       = step_reg;
        press_ev        = 1'b0;
        release_ev      = 1'b0;
        fall_base       = fall_count_reg;
        rise_base       = rise_count_reg;
        case (state_reg)
            S_UP:
            begin
                if (!pin_level)
                    state_next = S_FALLING;
            end
            S_FALLING:
            begin
                if (fall_count_reg >= debounce_count)
                begin
                    if (!pin_level)
                    begin
                        state_next      = S_DOWN;
                        press_time_next = now_ticks;
                        press_ev        = 1'b1;
                    end
                    else
                        state_next = S_UP;
                    fall_base = '0;
                end
                // counter ends at one after a decision
                fall_count_next = fall_base + 8'd1;
            end
            S_DOWN:
            begin
                if (pin_level)
                    state_next = S_RISING;
            end
            S_RISING:
            begin
                if (rise_count_reg >= debounce_count)
                begin
                    if (pin_level)
                    begin
                        state_next    = S_UP;
                        duration_next = bdsa_pkg::DURATION_W'(elapsed[DUR_W-1:0]);
                        release_ev    = 1'b1;
                        if (direction == bdsa_pkg::DIR_INC)
                            step_next = (step_reg < step_high_limit) ? step_reg + 10'd1
                                                                      : step_high_limit;
                        else if (direction == bdsa_pkg::DIR_DEC)
                            step_next = (step_reg > step_low_limit) ? step_reg - 10'd1
                                                                     : step_low_limit;
                    end
                    else
                        state_next = S_DOWN;
                    rise_base = '0;
                end
                rise_count_next = rise_base + 8'd1;
            end
            default:
            begin
                state_next = S_UP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_UP;
            fall_count_reg <= '0;
            rise_count_reg <= '0;
            press_time_reg <= '0;
            duration_reg   <= '0;
            step_reg       <= bdsa_pkg::STEP_LOW_LIMIT_RESET;
        end
        else if (step_en)
        begin
            state_reg      <= state_next;
            fall_count_reg <= fall_count_next;
            rise_count_reg <= rise_count_next;
            press_time_reg <= press_time_next;
            duration_reg   <= duration_next;
            step_reg       <= step_next;
        end
    end

    assign res.debounced_state = state_next;
    assign res.press_event     = press_ev;
    assign res.release_event   = release_ev;
    assign res.press_duration  = duration_next;
    assign res.step_value      = step_next;

    a_press_goes_down: assert property (@(posedge clk) disable iff (!rst_n)
        press_ev |-> (state_reg == S_FALLING && state_next == S_DOWN))
        else $error("press confirmed without falling to down");

    a_release_goes_up: assert property (@(posedge clk) disable iff (!rst_n)
        release_ev |-> (state_reg == S_RISING && state_next == S_UP))
        else $error("release confirmed without rising to up");

    a_step_only_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && !release_ev) |=> $stable(step_reg))
        else $error("step value moved without a confirmed release");

    a_fall_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && state_reg != S_FALLING) |=> $stable(fall_count_reg))
        else $error("fall counter moved outside falling state");

endmodule

`default_nettype wire

// ===== design/button_debounce_step_adjust.sv =====
// Button debounce with a saturating step value. One sample is taken per transfer and every
// sample gives exactly one result. The block takes a new sample in every cycle while the input
// side does not stall. A sample is held in the input register, and the state machine update then
// loads its result into the result register, which drives the outputs. The input side stalls
// only while a result waits in the result register and a sample waits in the input register.
// Configuration is written through cfg_we, cfg_index and cfg_data; index 3 is ignored.
`default_nettype none

module button_debounce_step_adjust #(
    parameter int TICK_WIDTH = bdsa_pkg::TICK_WIDTH_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [bdsa_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [bdsa_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               pin_level,
    input  wire logic [bdsa_pkg::DIR_W-1:0]         direction,
    input  wire logic [TICK_WIDTH-1:0]              now_ticks,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [bdsa_pkg::STATE_W-1:0]            debounced_state,
    output logic                                    press_event,
    output logic                                    release_event,
    output logic [bdsa_pkg::DURATION_W-1:0]         press_duration,
    output logic [bdsa_pkg::STEP_W-1:0]             step_value
);

    logic [bdsa_pkg::COUNT_W-1:0]   debounce_count_reg;
    logic [bdsa_pkg::STEP_W-1:0]    step_low_limit_reg;
    logic [bdsa_pkg::STEP_W-1:0]    step_high_limit_reg;

    logic                           s1_valid_reg;
    logic                           s1_pin_reg;
    logic [bdsa_pkg::DIR_W-1:0]     s1_dir_reg;
    logic [TICK_WIDTH-1:0]          s1_now_reg;

    logic                           out_valid_reg;
    bdsa_pkg::result_t              out_res_reg;
    bdsa_pkg::result_t              core_res;

    logic                           advance;
    logic                           step_en;

    // result register is free or being emptied this cycle
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign step_en  = s1_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_count_reg  <= bdsa_pkg::DEBOUNCE_COUNT_RESET;
            step_low_limit_reg  <= bdsa_pkg::STEP_LOW_LIMIT_RESET;
            step_high_limit_reg <= bdsa_pkg::STEP_HIGH_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bdsa_pkg::CFG_DEBOUNCE_COUNT:
                    debounce_count_reg <= cfg_data[bdsa_pkg::COUNT_W-1:0];
                bdsa_pkg::CFG_STEP_LOW_LIMIT:
                    step_low_limit_reg <= cfg_data[bdsa_pkg::STEP_W-1:0];
                bdsa_pkg::CFG_STEP_HIGH_LIMIT:
                    step_high_limit_reg <= cfg_data[bdsa_pkg::STEP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                s1_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_pin_reg <= pin_level;
            s1_dir_reg <= direction;
            s1_now_reg <= now_ticks;
        end
        if (step_en)
            out_res_reg <= core_res;
    end

    bdsa_core #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .step_en         (step_en),
        .pin_level       (s1_pin_reg),
        .direction       (s1_dir_reg),
        .now_ticks       (s1_now_reg),
        .debounce_count  (debounce_count_reg),
        .step_low_limit  (step_low_limit_reg),
        .step_high_limit (step_high_limit_reg),
        .res             (core_res)
    );

    assign out_valid       = out_valid_reg;
    assign debounced_state = out_res_reg.debounced_state;
    assign press_event     = out_res_reg.press_event;
    assign release_event   = out_res_reg.release_event;
    assign press_duration  = out_res_reg.press_duration;
    assign step_value      = out_res_reg.step_value;

endmodule

`default_nettype wire

// ===== bench/tb_button_debounce_step_adjust.sv =====
// testbench for the button debounce block with the saturating step value
`timescale 1ns / 1ps

module tb_button_debounce_step_adjust;

    localparam int TICK_W          = bdsa_pkg::TICK_WIDTH_DEFAULT;
    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 12;
    localparam int DRAIN_CYCLES    = 6;
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int MAX_REPORTS     = 40;
    localparam int NUM_PHASES      = 6;

    localparam logic [bdsa_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [bdsa_pkg::STATE_W-1:0] {
        BTN_UP      = 2'd0,
        BTN_DOWN    = 2'd1,
        BTN_FALLING = 2'd2,
        BTN_RISING  = 2'd3
    } btn_state_t;

    class debounce_scoreboard;
        logic [bdsa_pkg::COUNT_W-1:0] debounce_len;
        logic [bdsa_pkg::STEP_W-1:0]  low_limit;
        logic [bdsa_pkg::STEP_W-1:0]  high_limit;
        btn_state_t                   state;
        logic [bdsa_pkg::COUNT_W-1:0] fall_count;
        logic [bdsa_pkg::COUNT_W-1:0] rise_count;
        logic [TICK_W-1:0]            press_stamp;
        logic [TICK_W-1:0]            last_duration;
        logic [bdsa_pkg::STEP_W-1:0]  step;
        bdsa_pkg::result_t            awaited_results[$];
        int                           errors;
        int                           checked;
        int                           presses;
        int                           releases;
        int                           clamps;

        function new();
            debounce_len  = bdsa_pkg::DEBOUNCE_COUNT_RESET;
            low_limit     = bdsa_pkg::STEP_LOW_LIMIT_RESET;
            high_limit    = bdsa_pkg::STEP_HIGH_LIMIT_RESET;
            state         = BTN_UP;
            fall_count    = '0;
            rise_count    = '0;
            press_stamp   = '0;
            last_duration = '0;
            step          = bdsa_pkg::STEP_LOW_LIMIT_RESET;
            errors        = 0;
            checked       = 0;
            presses       = 0;
            releases      = 0;
            clamps        = 0;
        endfunction

        function void write_reg(logic [bdsa_pkg::CFG_INDEX_W-1:0] idx,
                                logic [bdsa_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                bdsa_pkg::CFG_DEBOUNCE_COUNT:  debounce_len = val[bdsa_pkg::COUNT_W-1:0];
                bdsa_pkg::CFG_STEP_LOW_LIMIT:  low_limit = val[bdsa_pkg::STEP_W-1:0];
                bdsa_pkg::CFG_STEP_HIGH_LIMIT: high_limit = val[bdsa_pkg::STEP_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic lvl, logic [bdsa_pkg::DIR_W-1:0] dir,
                                  logic [TICK_W-1:0] now);
            bdsa_pkg::result_t want;
            logic              pressed;
            logic              released;
            pressed  = 1'b0;
            released = 1'b0;
            case (state)
                BTN_UP:
                    if (!lvl)
                        state = BTN_FALLING;
                BTN_FALLING:
                begin
                    if (fall_count >= debounce_len)
                    begin
                        if (!lvl)
                        begin
                            state       = BTN_DOWN;
                            press_stamp = now;
                            pressed     = 1'b1;
                        end
                        else
                            state = BTN_UP;
                        fall_count = '0;
                    end
                    fall_count = fall_count + 8'd1;
                end
                BTN_DOWN:
                    if (lvl)
                        state = BTN_RISING;
                default:
                begin
                    if (rise_count >= debounce_len)
                    begin
                        if (lvl)
                        begin
                            state         = BTN_UP;
                            last_duration = now - press_stamp;
                            released      = 1'b1;
                            // limits are applied as written, even when crossed
                            if (dir == bdsa_pkg::DIR_INC)
                            begin
                                if (step < high_limit)
                                    step = step + 10'd1;
                                else
                                begin
                                    step = high_limit;
                                    clamps++;
                                end
                            end
                            else if (dir == bdsa_pkg::DIR_DEC)
                            begin
                                if (step > low_limit)
                                    step = step - 10'd1;
                                else
                                begin
                                    step = low_limit;
                                    clamps++;
                                end
                            end
                        end
                        else
                            state = BTN_DOWN;
                        rise_count = '0;
                    end
                    rise_count = rise_count + 8'd1;
                end
            endcase
            presses  += pressed;
            releases += released;
            want.debounced_state = state;
            want.press_event     = pressed;
            want.release_event   = released;
            want.press_duration  = last_duration[bdsa_pkg::DURATION_W-1:0];
            want.step_value      = step;
            awaited_results.push_back(want);
        endfunction

        function void compare_field(string fname, logic [31:0] want_v, logic [31:0] got_v);
            if (got_v !== want_v)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t mismatch %s: expected %0h actual %0h",
                             $time, fname, want_v, got_v);
            end
        endfunction

        function void check_result(bdsa_pkg::result_t got);
            bdsa_pkg::result_t want;
            if (awaited_results.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t unexpected result transfer: state %0d step %0d",
                             $time, got.debounced_state, got.step_value);
                return;
            end
            want = awaited_results.pop_front();
            checked++;
            compare_field("debounced_state", want.debounced_state, got.debounced_state);
            compare_field("press_event", want.press_event, got.press_event);
            compare_field("release_event", want.release_event, got.release_event);
            compare_field("press_duration", want.press_duration, got.press_duration);
            compare_field("step_value", want.step_value, got.step_value);
        endfunction
    endclass

    logic                                 clk = 1'b0;
    logic                                 rst_n;
    logic                                 cfg_we;
    logic [bdsa_pkg::CFG_INDEX_W-1:0]     cfg_index;
    logic [bdsa_pkg::CFG_DATA_W-1:0]      cfg_data;
    logic                                 in_valid;
    logic                                 in_stall;
    logic                                 pin_level;
    logic [bdsa_pkg::DIR_W-1:0]           direction;
    logic [TICK_W-1:0]                    now_ticks;
    logic                                 out_valid;
    logic                                 out_stall;
    logic [bdsa_pkg::STATE_W-1:0]         debounced_state;
    logic                                 press_event;
    logic                                 release_event;
    logic [bdsa_pkg::DURATION_W-1:0]      press_duration;
    logic [bdsa_pkg::STEP_W-1:0]          step_value;

    debounce_scoreboard     sb;
    logic                   hold_request;
    logic [TICK_W-1:0]      tick_now = '0;
    int                     items_sent = 0;
    int                     burst_left = 0;
    int                     settings_run = 0;
    int                     idle_cycles = 0;

    int phase_db[NUM_PHASES]    = '{3, 0, 1, 255, 2, 0};
    int phase_low[NUM_PHASES]   = '{113, 0, 500, 1023, 800, 0};
    int phase_high[NUM_PHASES]  = '{1019, 1023, 502, 0, 200, 0};
    int phase_items[NUM_PHASES] = '{120, 120, 120, 400, 120, 120};

    button_debounce_step_adjust dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .pin_level       (pin_level),
        .direction       (direction),
        .now_ticks       (now_ticks),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .debounced_state (debounced_state),
        .press_event     (press_event),
        .release_event   (release_event),
        .press_duration  (press_duration),
        .step_value      (step_value)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // result side: every accepted transfer goes against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(bdsa_pkg::result_t'({debounced_state, press_event,
                                                 release_event, press_duration,
                                                 step_value}));
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("no transfer for %0d cycles, giving up", WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // receiver stall pattern, with one long hold-off when asked for
    initial
    begin : receiver
        int mode;
        int mode_left;
        bit hold_done;
        mode      = 0;
        mode_left = 0;
        hold_done = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                repeat (HOLD_CYCLES)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            case (mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 9) < 3);
                default: out_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    task automatic send_sample(input logic lvl, input logic [bdsa_pkg::DIR_W-1:0] dir,
                               input logic [TICK_W-1:0] t);
        in_valid  <= 1'b1;
        pin_level <= lvl;
        direction <= dir;
        now_ticks <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_sample(lvl, dir, t);
        items_sent++;
    endtask

    // sender bursts with random gaps; ticks mostly advance, now and then jump
    task automatic offer_sample(input logic lvl);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
        end
        burst_left--;
        if ($urandom_range(0, 29) == 0)
            tick_now = $urandom();
        else
            tick_now = tick_now + $urandom_range(0, 3);
        send_sample(lvl, bdsa_pkg::DIR_W'($urandom_range(0, 3)), tick_now);
    endtask

    task automatic hold_level(input logic lvl, input int count);
        repeat (count)
            offer_sample(lvl);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [bdsa_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [bdsa_pkg::CFG_DATA_W-1:0] val);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        cfg_we    <= 1'b0;
    endtask

    // full press and release with a zero debounce count
    task automatic press_release(input logic [bdsa_pkg::DIR_W-1:0] dir,
                                 input logic [TICK_W-1:0] t_press,
                                 input logic [TICK_W-1:0] t_release);
        send_sample(1'b0, bdsa_pkg::DIR_W'($urandom_range(0, 3)), $urandom());
        send_sample(1'b0, bdsa_pkg::DIR_W'($urandom_range(0, 3)), t_press);
        send_sample(1'b1, bdsa_pkg::DIR_W'($urandom_range(0, 3)), $urandom());
        send_sample(1'b1, dir, t_release);
    endtask

    task automatic run_phase(input int n_items, input int db);
        int stop_at;
        int kind;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 6)
            begin
                hold_level(1'b0, db + $urandom_range(1, 4));
                hold_level(1'b1, db + $urandom_range(1, 4));
            end
            else if (kind == 7)
            begin
                // press that may not last long enough
                hold_level(1'b0, $urandom_range(1, db + 1));
                hold_level(1'b1, $urandom_range(1, 3));
            end
            else if (kind == 8)
            begin
                hold_level(1'b1, $urandom_range(1, db + 1));
                hold_level(1'b0, $urandom_range(1, 3));
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                    offer_sample(1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial
    begin : stimulus
        int p;
        sb           = new();
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        pin_level    = 1'b1;
        direction    = bdsa_pkg::DIR_DEC;
        now_ticks    = '0;
        hold_request = 1'b0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, then the limit and zero debounce corners
        send_sample(1'b1, bdsa_pkg::DIR_INC, '0);
        send_sample(1'b1, bdsa_pkg::DIR_DEC, '1);
        write_reg(bdsa_pkg::CFG_DEBOUNCE_COUNT, '0);
        write_reg(bdsa_pkg::CFG_STEP_HIGH_LIMIT, 10'd114);
        write_reg(CFG_UNUSED, '1);
        press_release(bdsa_pkg::DIR_INC, '1, 32'd6);
        press_release(bdsa_pkg::DIR_INC, 32'd100, 32'd90);
        // upper limit below the step value and below the lower limit
        write_reg(bdsa_pkg::CFG_STEP_HIGH_LIMIT, 10'd50);
        press_release(bdsa_pkg::DIR_INC, $urandom(), $urandom());
        // bounce while rising, then a decrement under the lower limit
        send_sample(1'b0, bdsa_pkg::DIR_INC, $urandom());
        send_sample(1'b0, bdsa_pkg::DIR_INC, $urandom());
        send_sample(1'b1, bdsa_pkg::DIR_INC, $urandom());
        send_sample(1'b0, bdsa_pkg::DIR_INC, $urandom());
        send_sample(1'b1, bdsa_pkg::DIR_INC, $urandom());
        send_sample(1'b1, bdsa_pkg::DIR_DEC, $urandom());
        // bounce while falling
        send_sample(1'b0, bdsa_pkg::DIR_DEC, $urandom());
        send_sample(1'b1, bdsa_pkg::DIR_DEC, $urandom());
        settings_run = 3;

        phase_db[NUM_PHASES-1]   = $urandom_range(0, 7);
        phase_low[NUM_PHASES-1]  = $urandom_range(0, 1023);
        phase_high[NUM_PHASES-1] = $urandom_range(0, 1023);
        for (p = 0; p < NUM_PHASES; p++)
        begin
            write_reg(bdsa_pkg::CFG_DEBOUNCE_COUNT, bdsa_pkg::CFG_DATA_W'(phase_db[p]));
            write_reg(bdsa_pkg::CFG_STEP_LOW_LIMIT, bdsa_pkg::CFG_DATA_W'(phase_low[p]));
            write_reg(bdsa_pkg::CFG_STEP_HIGH_LIMIT, bdsa_pkg::CFG_DATA_W'(phase_high[p]));
            if (p == 1)
                hold_request <= 1'b1;
            run_phase(phase_items[p], phase_db[p]);
            settings_run++;
        end
        drain_results();

        $display("covered %0d samples under %0d register settings, %0d results checked",
                 items_sent, settings_run, sb.checked);
        $display("confirmed %0d presses and %0d releases, %0d step moves held at a limit",
                 sb.presses, sb.releases, sb.clamps);
        if (sb.awaited_results.size() != 0)
            $display("%0d expected results never arrived", sb.awaited_results.size());
        if (sb.errors == 0 && sb.awaited_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
design/bdsa_pkg.sv
design/bdsa_core.sv
design/button_debounce_step_adjust.sv
bench/tb_button_debounce_step_adjust.sv
